// ----- hdl/chorus_modulated_delay_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the chorus delay block
// Concurrent checks clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef CHORUS_MODULATED_DELAY_MACROS_SVH
`define CHORUS_MODULATED_DELAY_MACROS_SVH

`ifndef SYNTHESIS
`define CMD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chorus delay check failed");
`define CMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chorus delay check failed");
`else
`define CMD_ASSERT_SAME(lbl, ante, cons)
`define CMD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/cmd_pkg.sv -----
// ---------------------------------------------------------------------------
// cmd_pkg
// Shared widths, reset values and register codes of the chorus delay.
// ---------------------------------------------------------------------------
package cmd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int HALF_W       = 15;
  localparam int PERIOD_W     = 16;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd195;

  // register index is paddr[2]
  typedef enum logic {
    REG_LFO_PERIOD = 1'b0
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [HALF_W-1:0]   half_t;

endpackage

// ----- hdl/cmd_mem.sv -----
// ---------------------------------------------------------------------------
// cmd_mem
// Delay line storage: one write and one registered read port.
// ---------------------------------------------------------------------------
module cmd_mem
  import cmd_pkg::*;
#(
  parameter int DEPTH = 340,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  half_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output half_t         rdata
);

  half_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // old data on a same-address collision; caller forwards
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/cmd_lfo.sv -----
// ---------------------------------------------------------------------------
// cmd_lfo
// Sweep control: period counter, delay length and direction.
// ---------------------------------------------------------------------------
`include "chorus_modulated_delay_macros.svh"

module cmd_lfo
  import cmd_pkg::*;
#(
  parameter int DEPTH = 340,
  parameter int AW    = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [PERIOD_W-1:0] period,
  output logic [AW-1:0]       tap_delay,
  output logic                led_next
);

  localparam logic [AW-1:0] TOP = AW'(DEPTH - 1);

  logic [PERIOD_W-1:0] cnt, cnt_next;
  logic [AW-1:0]       dl_next;
  logic                falling, falling_next;
  logic                led;
  logic                match;

  always_comb begin
    match        = (cnt == period);
    dl_next      = tap_delay;
    led_next     = led;
    cnt_next     = cnt + 1'b1;
    if (match) begin
      led_next = falling;
      cnt_next = PERIOD_W'(1);
      if (!falling) begin
        dl_next = tap_delay + 1'b1;
      end else if (tap_delay != '0) begin
        dl_next = tap_delay - 1'b1;
      end
    end
    falling_next = falling;
    if (dl_next >= TOP) begin
      falling_next = 1'b1;
    end
    if (dl_next <= AW'(1)) begin
      falling_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      tap_delay <= '0;
      falling   <= 1'b0;
      led       <= 1'b0;
    end else if (step) begin
      cnt       <= cnt_next;
      tap_delay <= dl_next;
      falling   <= falling_next;
      led       <= led_next;
    end
  end

  `CMD_ASSERT_SAME(a_dl_range, 1'b1, tap_delay <= TOP)
  `CMD_ASSERT_NEXT(a_cnt_restart, step && match, cnt == PERIOD_W'(1))
  `CMD_ASSERT_SAME(a_turn_at_top, tap_delay == TOP, falling)

endmodule

// ----- hdl/chorus_modulated_delay.sv -----
// ---------------------------------------------------------------------------
// chorus_modulated_delay
// Chorus: halved input plus half of a swept, delayed copy.
// Registered path: memory read, output reg. Throughput: one word per cycle
// unless out_ready stalls; one delay memory write and read per word.
// Reset: control clears at once; memory is not swept, unwritten entries
// read as zero through the wrap flag. No startup idle time.
// ---------------------------------------------------------------------------
`include "chorus_modulated_delay_macros.svh"

module chorus_modulated_delay
  import cmd_pkg::*;
#(
  parameter int DELAY_DEPTH = 340
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              in_valid,
  output logic              in_ready,
  input  sample_t           sample_in,
  // output stream
  output logic              out_valid,
  input  logic              out_ready,
  output sample_t           audio_out,
  output logic              rate_led,
  // config
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DELAY_DEPTH - 1);

  // config register
  logic [PERIOD_W-1:0] lfo_period;
  reg_idx_t            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_period <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_LFO_PERIOD) begin
      lfo_period <= pwdata[PERIOD_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LFO_PERIOD: prdata = APB_DW'(lfo_period);
      default:        prdata = '0;
    endcase
  end

  // accept stage
  logic          accept;
  logic          s1_move;
  half_t         half_in;
  logic [AW-1:0] wp, wp_next;
  logic          wrapped;
  logic [AW-1:0] tap_delay;
  logic          led_next;
  logic [AW:0]   diff;
  logic [AW-1:0] rd;
  half_t         rdata;

  assign accept  = in_valid && in_ready;
  assign half_in = sample_in[SAMPLE_W-1:1];
  assign wp_next = (wp == LAST) ? '0 : wp + 1'b1;

  always_comb begin
    diff = {1'b0, wp} - {1'b0, tap_delay};
    if (diff[AW]) begin
      rd = AW'(diff + DEPTH_X);
    end else begin
      rd = diff[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (accept) begin
      wp <= wp_next;
      if (wp == LAST) begin
        wrapped <= 1'b1;
      end
    end
  end

  cmd_lfo #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_lfo (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .period    (lfo_period),
    .tap_delay (tap_delay),
    .led_next  (led_next)
  );

  cmd_mem #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (half_in),
    .re    (accept),
    .raddr (rd),
    .rdata (rdata)
  );

  // read stage
  logic  s1_valid;
  half_t s1_half;
  logic  s1_fwd;
  logic  s1_blank;
  logic  s1_led;

  assign s1_move  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_half  <= half_in;
      s1_fwd   <= (rd == wp);                 // zero delay: the word just written
      s1_blank <= !wrapped && (rd > wp);      // never written since reset
      s1_led   <= led_next;
    end
  end

  // output stage
  half_t   delayed;
  sample_t mix;

  always_comb begin
    if (s1_fwd) begin
      delayed = s1_half;
    end else if (s1_blank) begin
      delayed = '0;
    end else begin
      delayed = rdata;
    end
    mix = sample_t'({{2{delayed[HALF_W-1]}}, delayed[HALF_W-1:1]})
        + sample_t'({s1_half[HALF_W-1], s1_half});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_move) begin
      audio_out <= mix;
      rate_led  <= s1_led;
    end
  end

  `CMD_ASSERT_SAME(a_wp_range, 1'b1, {1'b0, wp} < DEPTH_X)
  `CMD_ASSERT_NEXT(a_accept_loads, accept, s1_valid)
  `CMD_ASSERT_NEXT(a_stall_holds, s1_valid && out_valid && !out_ready, s1_valid)

endmodule

// ----- tb/chorus_modulated_delay_tb.sv -----
// ----------------------------------------------------------------------------
// chorus_modulated_delay_tb
// Self-checking bench for the chorus delay: a local model of the delay
// store and the sweep predicts every output word, and the period register
// is exercised through the APB port. Covers corner samples, period zero,
// full up/down sweeps, long backpressure, a period lowered under the
// counter and random traffic at several sweep periods.
// ----------------------------------------------------------------------------
module chorus_modulated_delay_tb;
  import cmd_pkg::*;

  localparam int DEPTH          = 340;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;

  localparam logic [APB_AW-1:0] ADDR_LFO_PERIOD = {REG_LFO_PERIOD, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED   = 3'b100;

  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;

  typedef struct packed {
    sample_t sample;
    logic    led;
  } chorus_word_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  sample_t           sample_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  sample_t           audio_out;
  logic              rate_led;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // local copy of the block state
  half_t               tap_mem [DEPTH];
  int unsigned         wr_ptr       = 0;
  int unsigned         tap_len      = 0;
  logic                sweep_down   = 1'b0;
  logic                led_q        = 1'b0;
  logic [PERIOD_W-1:0] sweep_cnt    = '0;
  logic [PERIOD_W-1:0] lfo_period_q = PERIOD_RESET;

  chorus_word_t chorus_out_q[$];
  int           fail_cnt     = 0;
  int           sent_total   = 0;
  int           idle_cycles  = 0;
  bit           src_idle     = 1'b1;
  bit           snk_idle     = 1'b1;
  bit           hold_request = 1'b0;

  chorus_modulated_delay #(.DELAY_DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .audio_out (audio_out),
    .rate_led  (rate_led),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic chorus_word_t predict_chorus(sample_t s);
    half_t        half_in;
    half_t        delayed;
    int           rd;
    chorus_word_t w;
    half_in = half_t'(s >>> 1);
    rd = int'(wr_ptr) - int'(tap_len);
    if (rd < 0) rd += DEPTH;
    // write lands before the read, so a zero delay returns this sample
    tap_mem[wr_ptr] = half_in;
    wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
    delayed = tap_mem[rd];
    if (sweep_cnt == lfo_period_q) begin
      led_q = sweep_down;
      if (!sweep_down) tap_len++;
      else if (tap_len > 0) tap_len--;
      sweep_cnt = '0;
    end
    sweep_cnt = sweep_cnt + 1'b1;
    if (tap_len >= DEPTH - 1) sweep_down = 1'b1;
    if (tap_len <= 1) sweep_down = 1'b0;
    w.sample = sample_t'(delayed >>> 1) + sample_t'(half_in);
    w.led    = led_q;
    return w;
  endfunction

  // input side: register writes and accepted words feed the model
  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr == ADDR_LFO_PERIOD)
        lfo_period_q = pwdata[PERIOD_W-1:0];
      if (in_valid && in_ready)
        chorus_out_q.push_back(predict_chorus(sample_in));
    end
  end

  always @(posedge clk) begin : check_out
    chorus_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (chorus_out_q.size() == 0) begin
        $error("unexpected word: audio_out=%0d rate_led=%0b", audio_out, rate_led);
        fail_cnt++;
      end else begin
        want = chorus_out_q.pop_front();
        if (audio_out !== want.sample) begin
          $error("audio_out: expected %0d, actual %0d", want.sample, audio_out);
          fail_cnt++;
        end
        if (rate_led !== want.led) begin
          $error("rate_led: expected %0b, actual %0b", want.led, rate_led);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("chorus_modulated_delay: mismatch");
        $finish;
      end
    end
  end

  // output side: random stall bursts, or one long hold on request
  initial begin : ready_driver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (snk_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input sample_t s);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    sent_total++;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      3:       return -1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic drain_chorus();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chorus_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_period_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_LFO_PERIOD;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(lfo_period_q)) begin
      $error("lfo_period: expected %0d, actual %0d", lfo_period_q, prdata);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are random, only the low 16 are kept
  task automatic set_lfo_period(input logic [PERIOD_W-1:0] period);
    drain_chorus();
    write_reg(ADDR_LFO_PERIOD, {16'($urandom), period});
    check_period_reg();
  endtask

  task automatic test_register_map();
    check_period_reg();
    write_reg(ADDR_UNMAPPED, $urandom);
    check_period_reg();
  endtask

  // period zero matches on the very first word after reset; the corner
  // samples then run at period one so the counter keeps matching
  task automatic test_period_zero();
    sample_t corner_samples[16] = '{
      16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'shFFFE,
      16'sh5555, 16'shAAAA, 16'sh4000, 16'shC000, 16'sh7FFE, 16'sh8001,
      16'sh3FFF, 16'shC001, 16'sh8000, 16'sh7FFF
    };
    set_lfo_period('0);
    send_sample(corner_samples[0]);
    set_lfo_period(16'd1);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
  endtask

  // one step per word: climbs to the top, turns, falls to the bottom
  task automatic test_full_sweep();
    set_lfo_period(16'd1);
    repeat (720) send_sample(pick_sample());
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (60) send_sample(pick_sample());
    drain_chorus();
  endtask

  task automatic test_random_periods();
    logic [PERIOD_W-1:0] period;
    period = 16'd1;
    // periods that never fall keep the counter from passing the period so sweeps go on
    repeat (4) begin
      period = period + PERIOD_W'($urandom_range(0, 5));
      set_lfo_period(period);
      repeat (160) send_sample(pick_sample());
    end
    drain_chorus();
    write_reg(ADDR_UNMAPPED, $urandom);
    set_lfo_period(16'hFFFF);
    repeat (150) send_sample(pick_sample());
    // lowered under the running counter: no steps for the rest of the run
    set_lfo_period(16'd3);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (150) send_sample(pick_sample());
  endtask

  initial begin
    foreach (tap_mem[i]) tap_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_map();
    test_period_zero();
    test_full_sweep();
    test_backpressure();
    test_random_periods();
    drain_chorus();
    if (fail_cnt == 0) $display("chorus_modulated_delay: match");
    else $display("chorus_modulated_delay: mismatch");
    $finish;
  end

endmodule
